// ===== rtl/nlp_pkg.sv =====
// numeric literal parser: shared types and constants
// beat structs, parse phase enum, control and class structs, radix codes and character codes
// no dependencies
package nlp_pkg;

    localparam int MAG_W  = 64;
    localparam int FRAC_W = 5;

    // most fraction digits kept in the mantissa
    localparam logic [FRAC_W-1:0] FRAC_LIMIT = 5'd19;

    // radix codes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_B  = 8'h62;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_HEX,
        PH_BIN,
        PH_DINT,
        PH_DFRAC,
        PH_STOP
    } t_phase;

    // input beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_empty;
        logic       is_last;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [MAG_W-1:0]  magnitude;
        logic              negative;
        logic [FRAC_W-1:0] frac_count;
        logic              not_a_number;
        logic              saturated;
        logic [1:0]        radix_kind;
    } t_out_beat;

    // decoded character
    typedef struct packed {
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_dec;
        logic       is_hex;
        logic       is_bin;
        logic       is_under;
        logic       is_dot;
        logic       is_x;
        logic       is_b;
        logic [3:0] dec_val;
        logic [3:0] hex_val;
    } t_char_class;

    // parse control state, mantissa kept apart
    typedef struct packed {
        t_phase            phase;
        logic              neg;
        logic [FRAC_W-1:0] frac;
        logic              ovf;
        logic [1:0]        radix;
    } t_lit_ctrl;

endpackage

// ===== rtl/numeric_literal_parser.sv =====
// numeric literal parser top level: one character beat in, one result beat per literal
// an input beat passes through the input register, then the result register
// throughput: one character per cycle while no result waits in a full result register; set by
//   the combinational multiply-add by 10, 16 or 2 and its overflow compare
// reset: synchronous active-low i_rst_n empties both registers and returns to start of literal
// depends on nlp_pkg, nlp_char_class, nlp_step
module numeric_literal_parser
    import nlp_pkg::*;
#(
    parameter int MANTISSA_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int W = MANTISSA_WIDTH;

    // parse state at the start of a literal
    localparam t_lit_ctrl CTRL_START = '{PH_START, 1'b0, '0, 1'b0, RADIX_DEC};

    logic         r_in_valid;
    t_in_beat     r_in;
    t_lit_ctrl    r_ctrl;
    logic [W-1:0] r_acc;
    logic         r_out_valid;
    t_out_beat    r_out;

    t_char_class  cls;
    t_lit_ctrl    n_ctrl;
    logic [W-1:0] n_acc;
    logic         emit;
    t_out_beat    n_out;
    logic         advance;

    // decode and update
    nlp_char_class u_class (
        .i_char  (r_in.char_code),
        .o_class (cls)
    );

    nlp_step #(
        .W (W)
    ) u_step (
        .i_beat   (r_in),
        .i_class  (cls),
        .i_ctrl   (r_ctrl),
        .i_acc    (r_acc),
        .o_ctrl   (n_ctrl),
        .o_acc    (n_acc),
        .o_emit   (emit),
        .o_result (n_out)
    );

    // a held beat moves on unless it has a result and the result register is full and not being read
    assign advance    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= CTRL_START;
            r_acc  <= '0;
        end else if (advance) begin
            r_ctrl <= n_ctrl;
            r_acc  <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |=> r_ctrl.phase == PH_START && r_acc == '0)
        else $error("state not cleared after a result");

    a_overflow_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.ovf |-> r_ctrl.phase == PH_STOP && r_acc == '1)
        else $error("overflow without clamp and stop");

    a_saturated_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.saturated |-> r_out.magnitude == MAG_W'({W{1'b1}}))
        else $error("saturated result not clamped");

    a_nan_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.not_a_number |->
            r_out.magnitude == '0 && !r_out.negative && !r_out.saturated)
        else $error("not-a-number result carries a value");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.frac_count <= FRAC_LIMIT
            && (r_out.frac_count == '0 || r_out.radix_kind == RADIX_DEC))
        else $error("fraction count out of range");

endmodule

// ===== rtl/nlp_char_class.sv =====
// numeric literal parser: character decoder
// sorts one byte into digit, sign, prefix and separator classes
// depends on nlp_pkg
module nlp_char_class
    import nlp_pkg::*;
(
    input  logic [7:0]  i_char,
    output t_char_class o_class
);

    logic up_hex;
    logic lo_hex;

    // letter ranges for hex digits
    assign up_hex = (i_char >= CH_UP_A) && (i_char <= CH_UP_F);
    assign lo_hex = (i_char >= CH_LO_A) && (i_char <= CH_LO_F);

    // class flags
    always_comb begin
        o_class          = '0;
        o_class.is_minus = (i_char == CH_MINUS);
        o_class.is_plus  = (i_char == CH_PLUS);
        o_class.is_zero  = (i_char == CH_ZERO);
        o_class.is_dec   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_class.is_hex   = o_class.is_dec || up_hex || lo_hex;
        o_class.is_bin   = (i_char == CH_ZERO) || (i_char == CH_ONE);
        o_class.is_under = (i_char == CH_UNDER);
        o_class.is_dot   = (i_char == CH_DOT);
        o_class.is_x     = (i_char == CH_UP_X) || (i_char == CH_LO_X);
        o_class.is_b     = (i_char == CH_UP_B) || (i_char == CH_LO_B);
        o_class.dec_val  = i_char[3:0];
        // letters: low nibble of 'A'/'a' is 1, plus 9 gives 10
        o_class.hex_val  = o_class.is_dec ? i_char[3:0] : i_char[3:0] + 4'd9;
    end

endmodule

// ===== rtl/nlp_step.sv =====
// numeric literal parser: per-character update
// phase transitions, mantissa multiply-add with overflow check, result build
// depends on nlp_pkg
module nlp_step
    import nlp_pkg::*;
#(
    parameter int W = 64
) (
    input  t_in_beat    i_beat,
    input  t_char_class i_class,
    input  t_lit_ctrl   i_ctrl,
    input  logic [W-1:0] i_acc,
    output t_lit_ctrl   o_ctrl,
    output logic [W-1:0] o_acc,
    output logic        o_emit,
    output t_out_beat   o_result
);

    localparam int EW = W + 4;

    logic [EW-1:0] acc_ext;
    logic [EW-1:0] scaled;
    logic [EW-1:0] sum;
    logic [3:0]    digit;
    logic          fits;
    logic          dec_path;
    t_lit_ctrl     n_ctrl;
    logic [W-1:0]  n_acc;

    // multiply-add by the current base, overflow when bits above W are set
    assign acc_ext = {4'b0, i_acc};
    always_comb begin
        unique case (i_ctrl.phase)
            PH_HEX:  scaled = acc_ext << 4;
            PH_BIN:  scaled = acc_ext << 1;
            default: scaled = (acc_ext << 3) + (acc_ext << 1);
        endcase
    end
    assign digit = (i_ctrl.phase == PH_HEX) ? i_class.hex_val : i_class.dec_val;
    assign sum   = scaled + EW'(digit);
    assign fits  = (sum[EW-1:W] == '0);

    // phase update
    always_comb begin
        n_ctrl   = i_ctrl;
        n_acc    = i_acc;
        dec_path = 1'b0;
        unique case (i_ctrl.phase)
            PH_START: begin
                if (i_class.is_minus) begin
                    n_ctrl.neg   = 1'b1;
                    n_ctrl.phase = PH_SIGNED;
                end else if (i_class.is_plus) begin
                    n_ctrl.phase = PH_SIGNED;
                end else if (i_class.is_zero) begin
                    n_ctrl.phase = PH_ZERO;
                end else begin
                    dec_path = 1'b1;
                end
            end
            PH_SIGNED: begin
                if (i_class.is_zero) begin
                    n_ctrl.phase = PH_ZERO;
                end else begin
                    dec_path = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_class.is_x) begin
                    n_ctrl.radix = RADIX_HEX;
                    n_ctrl.phase = PH_HEX;
                end else if (i_class.is_b) begin
                    n_ctrl.radix = RADIX_BIN;
                    n_ctrl.phase = PH_BIN;
                end else begin
                    dec_path = 1'b1;
                end
            end
            PH_HEX: begin
                if (i_class.is_hex) begin
                    if (fits) begin
                        n_acc = sum[W-1:0];
                    end else begin
                        n_acc        = '1;
                        n_ctrl.ovf   = 1'b1;
                        n_ctrl.phase = PH_STOP;
                    end
                end else if (!i_class.is_under) begin
                    n_ctrl.phase = PH_STOP;
                end
            end
            PH_BIN: begin
                if (i_class.is_bin) begin
                    if (fits) begin
                        n_acc = sum[W-1:0];
                    end else begin
                        n_acc        = '1;
                        n_ctrl.ovf   = 1'b1;
                        n_ctrl.phase = PH_STOP;
                    end
                end else if (!i_class.is_under) begin
                    n_ctrl.phase = PH_STOP;
                end
            end
            PH_DINT: begin
                dec_path = 1'b1;
            end
            PH_DFRAC: begin
                // extra fraction digits are dropped, never clamped
                if (i_class.is_dec && (i_ctrl.frac < FRAC_LIMIT) && fits) begin
                    n_acc       = sum[W-1:0];
                    n_ctrl.frac = i_ctrl.frac + 1'b1;
                end else begin
                    n_ctrl.phase = PH_STOP;
                end
            end
            PH_STOP: begin
            end
        endcase

        // decimal integer part
        if (dec_path) begin
            if (i_class.is_under) begin
                n_ctrl.phase = PH_DINT;
            end else if (i_class.is_dec) begin
                if (fits) begin
                    n_acc        = sum[W-1:0];
                    n_ctrl.phase = PH_DINT;
                end else begin
                    n_acc        = '1;
                    n_ctrl.ovf   = 1'b1;
                    n_ctrl.phase = PH_STOP;
                end
            end else if (i_class.is_dot) begin
                n_ctrl.phase = PH_DFRAC;
            end else begin
                n_ctrl.phase = PH_STOP;
            end
        end
    end

    // result and end-of-literal clear
    always_comb begin
        o_result = '0;
        o_ctrl   = n_ctrl;
        o_acc    = n_acc;
        o_emit   = i_beat.is_empty || i_beat.is_last;
        if (i_beat.is_empty) begin
            o_result.not_a_number = 1'b1;
        end else if (n_ctrl.phase == PH_SIGNED) begin
            o_result.not_a_number = 1'b1;
        end else begin
            o_result.magnitude  = MAG_W'(n_acc);
            o_result.negative   = n_ctrl.neg;
            o_result.frac_count = n_ctrl.frac;
            o_result.saturated  = n_ctrl.ovf;
            o_result.radix_kind = n_ctrl.radix;
        end
        if (o_emit) begin
            o_ctrl       = '0;
            o_ctrl.phase = PH_START;
            o_acc        = '0;
        end
    end

endmodule

// ===== verif/numeric_literal_parser_tb.sv =====
// self-checking testbench for numeric_literal_parser
// predicts every result from the character stream and checks it beat by beat
// depends on nlp_pkg and the numeric_literal_parser rtl
module numeric_literal_parser_tb
    import nlp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MAG_W-1:0] MANT_MAX = {MAG_W{1'b1}};
    localparam int HEX_SKIP       = 16;
    localparam int NOT_HEX        = -1;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_QUOTA   = 190;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    // literal state mirrored by the predictor
    t_phase           lit_phase;
    logic             lit_neg;
    logic [MAG_W-1:0] lit_mant;
    logic [FRAC_W-1:0] lit_frac;
    logic             lit_sat;
    logic [1:0]       lit_radix;

    t_out_beat pending_results[$];

    int sender_gap_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;
    int chars_sent = 0;
    int literals_sent = 0;
    int results_checked = 0;
    int nan_results = 0;
    int sat_results = 0;

    numeric_literal_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ---------------- predictor ----------------

    function automatic void clear_literal();
        lit_phase = PH_START;
        lit_neg   = 1'b0;
        lit_mant  = '0;
        lit_frac  = '0;
        lit_sat   = 1'b0;
        lit_radix = RADIX_DEC;
    endfunction

    // multiply-add one digit, refusing when the mantissa would overflow
    function automatic bit mant_push(input logic [MAG_W-1:0] base, input logic [MAG_W-1:0] digit);
        if (lit_mant > (MANT_MAX - digit) / base)
            return 1'b0;
        lit_mant = lit_mant * base + digit;
        return 1'b1;
    endfunction

    function automatic void mant_clamp();
        lit_mant  = MANT_MAX;
        lit_sat   = 1'b1;
        lit_phase = PH_STOP;
    endfunction

    function automatic bit is_dec_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (is_dec_char(c))
            return int'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c - CH_UP_A) + 10;
        if (c >= CH_LO_A && c <= CH_LO_F)
            return int'(c - CH_LO_A) + 10;
        if (c == CH_UNDER)
            return HEX_SKIP;
        return NOT_HEX;
    endfunction

    function automatic void dec_int_step(input logic [7:0] c);
        if (c == CH_UNDER) begin
            lit_phase = PH_DINT;
        end else if (is_dec_char(c)) begin
            if (mant_push(64'd10, 64'(c - CH_ZERO)))
                lit_phase = PH_DINT;
            else
                mant_clamp();
        end else if (c == CH_DOT) begin
            lit_phase = PH_DFRAC;
        end else begin
            lit_phase = PH_STOP;
        end
    endfunction

    function automatic void body_first_step(input logic [7:0] c);
        if (c == CH_ZERO)
            lit_phase = PH_ZERO;
        else
            dec_int_step(c);
    endfunction

    // advance the literal by one beat; returns 1 when a result is due
    function automatic bit predict_literal(input t_in_beat beat, output t_out_beat res);
        logic [7:0] c;
        int hv;
        c = beat.char_code;
        res = '0;
        if (beat.is_empty) begin
            res.not_a_number = 1'b1;
            clear_literal();
            return 1'b1;
        end
        case (lit_phase)
            PH_START: begin
                if (c == CH_MINUS) begin
                    lit_neg = 1'b1;
                    lit_phase = PH_SIGNED;
                end else if (c == CH_PLUS) begin
                    lit_phase = PH_SIGNED;
                end else begin
                    body_first_step(c);
                end
            end
            PH_SIGNED: body_first_step(c);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    lit_radix = RADIX_HEX;
                    lit_phase = PH_HEX;
                end else if (c == CH_LO_B || c == CH_UP_B) begin
                    lit_radix = RADIX_BIN;
                    lit_phase = PH_BIN;
                end else begin
                    dec_int_step(c);
                end
            end
            PH_HEX: begin
                hv = hex_digit_value(c);
                if (hv == NOT_HEX)
                    lit_phase = PH_STOP;
                else if (hv != HEX_SKIP && !mant_push(64'd16, 64'(hv)))
                    mant_clamp();
            end
            PH_BIN: begin
                if (c == CH_ZERO || c == CH_ONE) begin
                    if (!mant_push(64'd2, 64'(c - CH_ZERO)))
                        mant_clamp();
                end else if (c != CH_UNDER) begin
                    lit_phase = PH_STOP;
                end
            end
            PH_DINT: dec_int_step(c);
            PH_DFRAC: begin
                if (!is_dec_char(c) || lit_frac >= FRAC_LIMIT)
                    lit_phase = PH_STOP;
                else if (!mant_push(64'd10, 64'(c - CH_ZERO)))
                    lit_phase = PH_STOP;
                else
                    lit_frac = lit_frac + 1'b1;
            end
            default: ;
        endcase
        if (!beat.is_last)
            return 1'b0;
        if (lit_phase == PH_SIGNED) begin
            res.not_a_number = 1'b1;
        end else begin
            res.magnitude  = lit_mant;
            res.negative   = lit_neg;
            res.frac_count = lit_frac;
            res.saturated  = lit_sat;
            res.radix_kind = lit_radix;
        end
        clear_literal();
        return 1'b1;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("[%0t] result with nothing expected: %p", $realtime, o_out_data);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.not_a_number)
                    nan_results++;
                if (want.saturated)
                    sat_results++;
                if (o_out_data.magnitude !== want.magnitude
                        || o_out_data.negative !== want.negative
                        || o_out_data.frac_count !== want.frac_count
                        || o_out_data.not_a_number !== want.not_a_number
                        || o_out_data.saturated !== want.saturated
                        || o_out_data.radix_kind !== want.radix_kind) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("[%0t] mismatch on result %0d", $realtime, results_checked);
                        $display("    expected mag=%h neg=%b frac=%0d nan=%b sat=%b radix=%0d",
                                 want.magnitude, want.negative, want.frac_count,
                                 want.not_a_number, want.saturated, want.radix_kind);
                        $display("    actual   mag=%h neg=%b frac=%0d nan=%b sat=%b radix=%0d",
                                 o_out_data.magnitude, o_out_data.negative,
                                 o_out_data.frac_count, o_out_data.not_a_number,
                                 o_out_data.saturated, o_out_data.radix_kind);
                    end
                end
            end
        end
    end

    // ---------------- character driver ----------------

    function automatic t_in_beat make_beat(input logic [7:0] c, input logic empty, input logic last);
        t_in_beat b;
        b.char_code = c;
        b.is_empty  = empty;
        b.is_last   = last;
        return b;
    endfunction

    // one character beat, with random idle cycles ahead of it
    task automatic send_beat(input t_in_beat beat);
        t_out_beat res;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        chars_sent++;
        if (predict_literal(beat, res))
            pending_results.push_back(res);
    endtask

    // sender holds off until every expected result is back
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // whole literal, now and then broken up by an empty beat
    task automatic send_literal(input logic [7:0] lit[$]);
        literals_sent++;
        if (lit.size() == 0) begin
            send_beat(make_beat(8'($urandom_range(255)), 1'b1, 1'b1));
            return;
        end
        foreach (lit[i]) begin
            if ($urandom_range(99) < 2)
                send_beat(make_beat(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1))));
            send_beat(make_beat(lit[i], 1'b0, i == lit.size() - 1));
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] lit[$];
        for (int i = 0; i < s.len(); i++)
            lit.push_back(s[i]);
        send_literal(lit);
    endtask

    // ---------------- random literal generation ----------------

    function automatic int pick_len(input int short_max, input int long_lo, input int long_hi);
        if ($urandom_range(99) < 12)
            return $urandom_range(long_hi, long_lo);
        return $urandom_range(short_max);
    endfunction

    function automatic void add_digits(ref logic [7:0] lit[$], input int count,
                                       input logic [1:0] radix_sel, input bit with_under);
        int v;
        for (int i = 0; i < count; i++) begin
            if (with_under && $urandom_range(6) == 0)
                lit.push_back(CH_UNDER);
            case (radix_sel)
                RADIX_HEX: begin
                    v = $urandom_range(15);
                    if (v < 10)
                        lit.push_back(CH_ZERO + 8'(v));
                    else if ($urandom_range(1))
                        lit.push_back(CH_LO_A + 8'(v - 10));
                    else
                        lit.push_back(CH_UP_A + 8'(v - 10));
                end
                RADIX_BIN: lit.push_back(CH_ZERO + 8'($urandom_range(1)));
                default:   lit.push_back(CH_ZERO + 8'($urandom_range(9)));
            endcase
        end
    endfunction

    function automatic void random_literal(ref logic [7:0] lit[$]);
        int kind;
        int r;
        string near_max;
        near_max = "1844674407370955161";
        kind = $urandom_range(99);
        r = $urandom_range(3);
        if (kind < 85) begin
            if (r == 0)
                lit.push_back(CH_MINUS);
            else if (r == 1)
                lit.push_back(CH_PLUS);
        end
        if (kind < 30) begin
            // decimal integer, sometimes right at the mantissa limit
            if ($urandom_range(99) < 15) begin
                for (int i = 0; i < near_max.len(); i++)
                    lit.push_back(near_max[i]);
                add_digits(lit, $urandom_range(2, 1), RADIX_DEC, 1'b0);
            end else begin
                add_digits(lit, pick_len(8, 18, 23) + 1, RADIX_DEC, 1'b1);
            end
        end else if (kind < 50) begin
            // decimal with fraction
            add_digits(lit, pick_len(6, 15, 21), RADIX_DEC, 1'b1);
            lit.push_back(CH_DOT);
            add_digits(lit, pick_len(6, 18, 23), RADIX_DEC, 1'b0);
        end else if (kind < 65) begin
            lit.push_back(CH_ZERO);
            lit.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
            add_digits(lit, pick_len(8, 15, 18), RADIX_HEX, 1'b1);
        end else if (kind < 77) begin
            lit.push_back(CH_ZERO);
            lit.push_back($urandom_range(1) ? CH_LO_B : CH_UP_B);
            add_digits(lit, pick_len(10, 62, 66), RADIX_BIN, 1'b1);
        end else if (kind < 85) begin
            // a valid head then a stray byte and trailing junk
            add_digits(lit, $urandom_range(4, 1), RADIX_DEC, 1'b0);
            for (int i = $urandom_range(3, 1); i > 0; i--)
                lit.push_back(8'($urandom_range(255)));
        end else if (kind < 93) begin
            // raw noise over the full byte range
            for (int i = $urandom_range(5, 1); i > 0; i--)
                lit.push_back(8'($urandom_range(255)));
        end else if (kind < 96) begin
            lit.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        end else if (kind < 98) begin
            lit.push_back(CH_ZERO);
        end
        // otherwise the literal stays empty
    endfunction

    // ---------------- tests ----------------

    task automatic test_plain_literals();
        string plain[] = '{"0", "-0", "+7", "123", "-98.76", "0x1F_aB", "0XC", "-0b1_01",
                           "0B0", "1_000", "3.", ".5", "12.3_4", "007"};
        foreach (plain[i])
            send_text(plain[i]);
    endtask

    task automatic test_special_cases();
        logic [7:0] lit[$];
        // not a number: empty literal and lone signs
        send_beat(make_beat(8'h00, 1'b1, 1'b1));
        send_beat(make_beat(8'hFF, 1'b1, 1'b1));
        send_text("-");
        send_text("+");
        // bare prefixes
        send_text("0x");
        send_text("0b");
        // empty beat drops a partial literal
        send_beat(make_beat(CH_ONE, 1'b0, 1'b0));
        send_beat(make_beat(8'hA5, 1'b1, 1'b0));
        send_text("42");
        // high bytes and nul
        lit = '{CH_ONE, 8'h80};
        send_literal(lit);
        lit = '{8'hFF};
        send_literal(lit);
        lit = '{8'h00, CH_ONE};
        send_literal(lit);
        // mantissa limit and overflow in decimal and hex
        send_text("18446744073709551615");
        send_text("-18446744073709551616");
        send_text("0xffff_ffff_ffff_FFFF");
        send_text("0x1_0000_0000_0000_0000");
        // fraction digit limit
        send_text("0.12345678901234567890123");
        send_text("9abc");
        send_text("--1");
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        logic [7:0] lit[$];
        int stop_at;
        wait_results_drained();
        sender_gap_pct = gap_pct;
        receiver_stall_pct = stall_pct;
        stop_at = chars_sent + RANDOM_QUOTA;
        while (chars_sent < stop_at) begin
            lit.delete();
            random_literal(lit);
            send_literal(lit);
            if ($urandom_range(49) == 0)
                wait_results_drained();
        end
    endtask

    // ---------------- run control ----------------

    initial begin
        int waited;
        clear_literal();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_literals();
        test_special_cases();
        test_random_traffic(0, 0);
        test_random_traffic(65, 0);
        test_random_traffic(0, 65);
        test_random_traffic(36, 36);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            $display("sent %0d characters in %0d literals; checked %0d results",
                     chars_sent, literals_sent, results_checked);
            $display("of those %0d not-a-number and %0d saturated; %0d errors",
                     nan_results, sat_results, error_count);
            if (error_count == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
            $finish;
        end
    end

    // hard stop if the handshake hangs
    initial begin
        #2_000_000;
        $display("run timed out");
        $display("== FAIL ==");
        $finish;
    end

endmodule
